// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FGPL_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a cause seen at one edge is followed by its effect at the next edge.
`define FGPL_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ----- rtl/fgpl_pkg.sv -----
// Package for the functional graph path length block: sizes, codes and payload types.
// Depends on nothing; used by the top level and the testbench.
package fgpl_pkg;

   localparam int MAX_NODES = 1024;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_SOLVE = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] successor;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      logic [CNT_W-1:0]  path_length;
   } rsp_type;

   // One entry of the visit table: visited flag, id of the walk that marked it,
   // and its position on that walk's stack.
   typedef struct packed {
      logic              vis;
      logic [NODE_W-1:0] id;
      logic [NODE_W-1:0] pos;
   } mark_type;

   localparam int MARK_W = $bits(mark_type);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_CLEAR   = 10'b00_0000_0010,
      S_START   = 10'b00_0000_0100,
      S_ISSUE   = 10'b00_0000_1000,
      S_EVAL    = 10'b00_0001_0000,
      S_BASE    = 10'b00_0010_0000,
      S_NEXT    = 10'b00_0100_0000,
      S_L_INIT  = 10'b00_1000_0000,
      S_L_ISSUE = 10'b01_0000_0000,
      S_L_WRITE = 10'b10_0000_0000
   } state_type;

endpackage

// ----- rtl/fgpl_ram.sv -----
// Generic simple dual port RAM: one write port, one read port with registered data.
// Depends on nothing.
module fgpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/functional_graph_path_lengths.sv -----
// Top level of the functional graph path length block: sequencer, shared adder, tables.
// Depends on fgpl_pkg, fgpl_ram and assert_macros.svh.
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+------------------------------
//  request  | start, busy, req_payload              | transfer when start & !busy
//  response | rsp_valid, rsp_payload                | one-cycle strobe, no backpressure
//  config   | csr_valid, csr_ready, csr_data        | transfer when csr_valid & csr_ready
//
// Loads and reads can follow back to back; a read's result appears on the
// response ports in the cycle after its transfer.
// Solve holds busy high while it sweeps the visit table clear, then for each start
// node either skips it when already visited or walks its chain and labels every
// walked node, and then returns to idle.
// Reset is synchronous: node_count returns to 1024, the sequencer goes idle.
// The response side cannot stall; nothing waits on it.
`include "assert_macros.svh"

module functional_graph_path_lengths
   import fgpl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   // Control registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  ncount_ff, ncount_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [NODE_W-1:0] rd_node_ff, rd_node_in;

   // Walk registers
   logic [NODE_W-1:0] clr_ff, clr_in;    // clear sweep address
   logic [CNT_W-1:0]  i_ff, i_in;        // current start node
   logic [NODE_W-1:0] v_ff, v_in;        // node under the walk
   logic [CNT_W-1:0]  cnt_ff, cnt_in;    // nodes pushed on the walk stack
   logic [NODE_W-1:0] hit_ff, hit_in;    // stack position where the walk closed
   logic              onw_ff, onw_in;    // walk closed on itself
   logic [CNT_W-1:0]  val_ff, val_in;    // label being written
   logic [NODE_W-1:0] k_ff, k_in;        // stack index being labelled
   logic              tail_ff, tail_in;  // bump the label after this entry
   logic              last_ff, last_in;  // this entry is the bottom of the stack

   // Table ports
   logic              succ_we;
   logic [NODE_W-1:0] succ_q;
   logic              mark_we;
   logic [NODE_W-1:0] mark_waddr;
   mark_type          mark_wdata;
   logic [MARK_W-1:0] mark_raw;
   mark_type          mark_q;
   logic              stack_we;
   logic [NODE_W-1:0] stack_q;
   logic              len_we;
   logic [NODE_W-1:0] len_raddr;
   logic [CNT_W-1:0]  len_q;

   // Shared adder
   logic [CNT_W-1:0]  alu_a, alu_b, alu_res;
   logic              alu_sub;

   logic              accept;
   logic              rd_go;
   logic              solve_go;
   logic [NODE_W-1:0] next_v;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign rd_go     = accept && (req_payload.func == FUNC_READ);
   assign solve_go  = accept && (req_payload.func == FUNC_SOLVE);
   assign mark_q    = mark_type'(mark_raw);

   // Successors at or beyond node_count point back at the node itself.
   assign next_v = ({1'b0, succ_q} < ncount_ff) ? succ_q : v_ff;

   // Successor table: written by loads, read at the walk node.
   assign succ_we = accept && (req_payload.func == FUNC_LOAD);

   fgpl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_succ_ram (
      .clock   (clock),
      .wr_en   (succ_we),
      .wr_addr (req_payload.node),
      .wr_data (req_payload.successor),
      .rd_addr (v_ff),
      .rd_data (succ_q)
   );

   // Visit table: swept to zero at solve, marked as the walk advances.
   always_comb begin
      mark_we    = 1'b0;
      mark_waddr = v_ff;
      mark_wdata = '0;
      if (state_ff == S_CLEAR) begin
         mark_we    = 1'b1;
         mark_waddr = clr_ff;
      end else if (state_ff == S_EVAL && !mark_q.vis) begin
         mark_we        = 1'b1;
         mark_wdata.vis = 1'b1;
         mark_wdata.id  = i_ff[NODE_W-1:0];
         mark_wdata.pos = cnt_ff[NODE_W-1:0];
      end
   end

   fgpl_ram #(.WIDTH(MARK_W), .DEPTH(MAX_NODES)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (MARK_W'(mark_wdata)),
      .rd_addr (v_ff),
      .rd_data (mark_raw)
   );

   // Walk stack: pushed while walking, popped from the top while labelling.
   assign stack_we = (state_ff == S_EVAL) && !mark_q.vis;

   fgpl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (cnt_ff[NODE_W-1:0]),
      .wr_data (v_ff),
      .rd_addr (k_ff),
      .rd_data (stack_q)
   );

   // Length table: read by read items when idle, by the walk to fetch a known label.
   assign len_we    = (state_ff == S_L_WRITE);
   assign len_raddr = (state_ff == S_EVAL) ? v_ff : req_payload.node;

   fgpl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (stack_q),
      .wr_data (val_ff),
      .rd_addr (len_raddr),
      .rd_data (len_q)
   );

   // One adder serves every count, index and label step of the sequencer.
   always_comb begin
      alu_a   = cnt_ff;
      alu_b   = CNT_W'(1);
      alu_sub = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            alu_a = {1'b0, clr_ff};
         end
         S_EVAL: begin
            if (mark_q.vis) begin
               alu_b   = {1'b0, mark_q.pos};
               alu_sub = 1'b1;
            end
         end
         S_BASE: begin
            alu_a = len_q;
         end
         S_NEXT: begin
            alu_a = i_ff;
         end
         S_L_INIT: begin
            alu_sub = 1'b1;
         end
         S_L_ISSUE: begin
            alu_a   = {1'b0, k_ff};
            alu_sub = 1'b1;
         end
         S_L_WRITE: begin
            alu_a = val_ff;
            alu_b = {{(CNT_W-1){1'b0}}, tail_ff};
         end
         default: begin
            alu_a = cnt_ff;
         end
      endcase
      alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(CNT_W-1){1'b0}}, alu_sub};
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      ncount_in  = ncount_ff;
      rd_pend_in = rd_go;
      rd_node_in = req_payload.node;
      clr_in     = clr_ff;
      i_in       = i_ff;
      v_in       = v_ff;
      cnt_in     = cnt_ff;
      hit_in     = hit_ff;
      onw_in     = onw_ff;
      val_in     = val_ff;
      k_in       = k_ff;
      tail_in    = tail_ff;
      last_in    = last_ff;

      // Clamp the node count into 1 .. MAX_NODES.
      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            ncount_in = CNT_W'(1);
         end else if (csr_data > CNT_W'(MAX_NODES)) begin
            ncount_in = CNT_W'(MAX_NODES);
         end else begin
            ncount_in = csr_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (solve_go) begin
               clr_in   = '0;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            clr_in = alu_res[NODE_W-1:0];
            if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
               i_in     = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (i_ff >= ncount_ff) begin
               state_in = S_IDLE;
            end else begin
               v_in     = i_ff[NODE_W-1:0];
               cnt_in   = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!mark_q.vis) begin
               // Push and advance along the chain.
               cnt_in   = alu_res;
               v_in     = next_v;
               state_in = S_ISSUE;
            end else if (cnt_ff == '0) begin
               state_in = S_NEXT;
            end else if (mark_q.id == i_ff[NODE_W-1:0]) begin
               // Closed on this walk: cycle length is count minus entry position.
               onw_in   = 1'b1;
               hit_in   = mark_q.pos;
               val_in   = alu_res;
               state_in = S_L_INIT;
            end else begin
               // Ran into an earlier walk: fetch its label.
               onw_in   = 1'b0;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            val_in   = alu_res;
            state_in = S_L_INIT;
         end
         S_NEXT: begin
            i_in     = alu_res;
            state_in = S_START;
         end
         S_L_INIT: begin
            k_in     = alu_res[NODE_W-1:0];
            state_in = S_L_ISSUE;
         end
         S_L_ISSUE: begin
            tail_in  = !onw_ff || (k_ff <= hit_ff);
            last_in  = (k_ff == '0);
            k_in     = alu_res[NODE_W-1:0];
            state_in = S_L_WRITE;
         end
         S_L_WRITE: begin
            val_in   = alu_res;
            state_in = last_ff ? S_NEXT : S_L_ISSUE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ncount_ff  <= CNT_W'(MAX_NODES);
         rd_pend_ff <= 1'b0;
         i_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         ncount_ff  <= ncount_in;
         rd_pend_ff <= rd_pend_in;
         i_ff       <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_node_ff <= rd_node_in;
      clr_ff     <= clr_in;
      v_ff       <= v_in;
      cnt_ff     <= cnt_in;
      hit_ff     <= hit_in;
      onw_ff     <= onw_in;
      val_ff     <= val_in;
      k_ff       <= k_in;
      tail_ff    <= tail_in;
      last_ff    <= last_in;
   end

   // Response: the label read at the transfer edge, presented in the cycle after.
   assign rsp_valid               = rd_pend_ff;
   assign rsp_payload.node_out    = rd_node_ff;
   assign rsp_payload.path_length = len_q;

   `FGPL_ASSERT_NEXT(a_read_resp, rd_go, rsp_valid, "read without response")
   `FGPL_ASSERT_NEXT(a_solve_clear, solve_go, state_ff == S_CLEAR, "solve did not start clear")
   `FGPL_ASSERT(a_stack_room, !stack_we || cnt_ff < CNT_W'(MAX_NODES), "walk stack overflow")
   `FGPL_ASSERT_NEXT(a_label_done, len_we && last_ff, state_ff == S_NEXT, "labels did not end")

endmodule

// ----- test/tb_functional_graph_path_lengths.sv -----
`timescale 1ns / 1ps
// Testbench for functional_graph_path_lengths: directed and random load/solve/read traffic
// checked against an in-bench mirror of the successor and length tables.
// Depends on fgpl_pkg and the functional_graph_path_lengths RTL.
module tb_functional_graph_path_lengths;
   import fgpl_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 560;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SETTLE_LIMIT = 40000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_payload;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data;

   // Mirror of the block: successor table, length labels and node count.
   logic [NODE_W-1:0] succ_mirror [MAX_NODES];
   logic [CNT_W-1:0]  len_mirror  [MAX_NODES];
   bit                seen        [MAX_NODES];
   int                trail       [MAX_NODES];
   int                count_mirror;

   rsp_type pending_lengths [$];
   rsp_type head_length;
   int      failures;
   int      cycles;
   bit      quiet;

   functional_graph_path_lengths dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Successor as the solve sees it: out-of-range successors loop back to the node.
   function automatic int next_node(input int v);
      int s;
      s = succ_mirror[v];
      return (s < count_mirror) ? s : v;
   endfunction

   // Label every node below the node count with its count of distinct reachable nodes.
   function automatic void solve_lengths();
      int v;
      int depth;
      int hit;
      logic [CNT_W-1:0] run;
      foreach (seen[i]) seen[i] = 1'b0;
      for (int s = 0; s < count_mirror; s++) begin
         if (!seen[s]) begin
            v = s;
            depth = 0;
            while (!seen[v]) begin
               seen[v] = 1'b1;
               trail[depth] = v;
               depth++;
               v = next_node(v);
            end
            hit = -1;
            for (int k = 0; k < depth; k++) begin
               if (hit < 0 && trail[k] == v) hit = k;
            end
            if (hit >= 0) begin
               // Walk closed on itself: cycle members get the cycle length, tail counts up.
               for (int k = hit; k < depth; k++) len_mirror[trail[k]] = CNT_W'(depth - hit);
               for (int k = hit - 1; k >= 0; k--) begin
                  len_mirror[trail[k]] = len_mirror[trail[k + 1]] + 1'b1;
               end
            end else begin
               // Walk ran into an earlier walk: extend that node's label.
               run = len_mirror[v];
               for (int k = depth - 1; k >= 0; k--) begin
                  run = run + 1'b1;
                  len_mirror[trail[k]] = run;
               end
            end
         end
      end
   endfunction

   function automatic void apply_transfer(input req_type item);
      rsp_type want;
      case (item.func)
         FUNC_LOAD:  succ_mirror[item.node] = item.successor;
         FUNC_SOLVE: solve_lengths();
         FUNC_READ: begin
            want.node_out    = item.node;
            want.path_length = len_mirror[item.node];
            pending_lengths.insert(pending_lengths.size(), want);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_item(input logic [1:0] f, input int n, input int s);
      req_type item;
      item.func      = f;
      item.node      = n[NODE_W-1:0];
      item.successor = s[NODE_W-1:0];
      return item;
   endfunction

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 9);
   endfunction

   // Present one item from a falling edge, hold it until the transfer, then maybe idle.
   // With no gap, start stays high: the caller drives the next item or calls settle.
   task automatic send_item(input req_type item);
      int gap;
      start = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      apply_transfer(item);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         req_payload = make_item(2'($urandom_range(0, 3)), $urandom, $urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop start and wait for every read to report and the solve engine to go idle.
   task automatic settle();
      int waited;
      start = 1'b0;
      waited = 0;
      @(negedge clock);
      while ((pending_lengths.size() != 0 || busy !== 1'b0) && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      if (pending_lengths.size() != 0) begin
         $error("%0d expected path lengths never reported", pending_lengths.size());
         failures++;
         pending_lengths.delete();
      end
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] value);
      settle();
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      if (value == 0) count_mirror = 1;
      else if (value > MAX_NODES) count_mirror = MAX_NODES;
      else count_mirror = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One ring through all nodes: fills the whole table and gives the longest label.
   task automatic test_full_ring();
      write_node_count(11'h7FF);
      for (int i = 0; i < MAX_NODES; i++) begin
         send_item(make_item(FUNC_LOAD, i, (i + 1) % MAX_NODES));
      end
      send_item(make_item(FUNC_SOLVE, $urandom, $urandom));
      send_item(make_item(FUNC_READ, 0, 0));
      send_item(make_item(FUNC_READ, MAX_NODES - 1, MAX_NODES - 1));
      send_item(make_item(FUNC_READ, 512, 0));
      settle();
   endtask

   // Zero count clamps to one node; above the table size clamps to the full table.
   task automatic test_count_extremes();
      write_node_count(11'd0);
      send_item(make_item(FUNC_SOLVE, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0));
      send_item(make_item(FUNC_READ, MAX_NODES - 1, 0));
      write_node_count(11'd1);
      send_item(make_item(FUNC_SOLVE, MAX_NODES - 1, MAX_NODES - 1));
      send_item(make_item(FUNC_READ, 0, 0));
      write_node_count(11'd1025);
      send_item(make_item(FUNC_SOLVE, 0, 0));
      send_item(make_item(FUNC_READ, 700, 0));
      write_node_count(11'd1024);
      settle();
   endtask

   // Small graph: chain into an out-of-range successor, a loop of two nodes, a self loop,
   // a tail that joins an earlier walk, and a load beyond the node count.
   task automatic test_successor_range();
      int succ_of [8] = '{1, 2, 3, 900, 5, 4, 6, 3};
      write_node_count(11'd8);
      for (int i = 0; i < 8; i++) send_item(make_item(FUNC_LOAD, i, succ_of[i]));
      send_item(make_item(FUNC_LOAD, 1000, 1000));
      send_item(make_item(FUNC_SOLVE, 0, 0));
      for (int i = 0; i < 8; i++) send_item(make_item(FUNC_READ, i, 0));
      send_item(make_item(FUNC_READ, 1000, 0));
      settle();
   endtask

   // The spare function code must neither answer nor disturb the tables.
   task automatic test_unused_func();
      send_item(make_item(FUNC_UNUSED, MAX_NODES - 1, MAX_NODES - 1));
      send_item(make_item(FUNC_UNUSED, 0, 0));
      send_item(make_item(FUNC_READ, 3, 0));
      send_item(make_item(FUNC_READ, MAX_NODES - 1, 0));
      settle();
   endtask

   // Phases under a fresh node count: mostly load/solve/read sequences, some noise.
   // All entries are defined after the ring test, so any node may be read.
   task automatic test_random_traffic();
      int issued;
      int sel;
      int raw;
      int n;
      int node;
      int succ;
      req_type item;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 15);
         if (sel == 0) raw = $urandom_range(1024, 2047);
         else if (sel == 1) raw = $urandom_range(0, 1);
         else if (sel == 2) raw = $urandom_range(1, 1024);
         else raw = $urandom_range(2, 24);
         write_node_count(raw[CNT_W-1:0]);
         n = count_mirror;
         quiet = (issued > RANDOM_ITEMS * 7 / 8) || ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(1, (n < 20) ? n : 20)) begin
               node = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                                  : $urandom_range(0, n - 1);
               if ($urandom_range(0, 6) == 0 && n < MAX_NODES)
                  succ = $urandom_range(n, MAX_NODES - 1);
               else
                  succ = $urandom_range(0, n - 1);
               if ($urandom_range(0, 19) == 0)
                  send_item(make_item(FUNC_UNUSED, $urandom, $urandom));
               send_item(make_item(FUNC_LOAD, node, succ));
               issued++;
            end
            send_item(make_item(FUNC_SOLVE, $urandom, $urandom));
            issued++;
            repeat ($urandom_range(2, 8)) begin
               node = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                                  : $urandom_range(0, n - 1);
               send_item(make_item(FUNC_READ, node, $urandom));
               issued++;
            end
         end else begin
            repeat ($urandom_range(4, 16)) begin
               item = make_item(2'($urandom_range(0, 3)), $urandom, $urandom);
               send_item(item);
               if (item.func != FUNC_UNUSED) issued++;
            end
         end
      end
      settle();
   endtask

   // Each strobed result is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_lengths.size() == 0) begin
            $error("result with no read waiting: node_out %0d path_length %0d",
                   rsp_payload.node_out, rsp_payload.path_length);
            failures++;
         end else begin
            head_length = pending_lengths.pop_front();
            if (rsp_payload.node_out !== head_length.node_out) begin
               $error("node_out: expected %0d, got %0d",
                      head_length.node_out, rsp_payload.node_out);
               failures++;
            end
            if (rsp_payload.path_length !== head_length.path_length) begin
               $error("path_length: expected %0d, got %0d (node %0d)",
                      head_length.path_length, rsp_payload.path_length,
                      head_length.node_out);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      failures     = 0;
      cycles       = 0;
      quiet        = 1'b0;
      count_mirror = MAX_NODES;
      foreach (succ_mirror[i]) succ_mirror[i] = '0;
      foreach (len_mirror[i]) len_mirror[i] = '0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_full_ring();
      test_count_extremes();
      test_successor_range();
      test_unused_func();
      test_random_traffic();

      settle();
      repeat (16) @(negedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
